// ===== src/mt19937_generator_bank_core_assert.svh =====
// Assertion macros shared by the checker.
`ifndef MT19937_GENERATOR_BANK_CORE_ASSERT_SVH
`define MT19937_GENERATOR_BANK_CORE_ASSERT_SVH
`define MTGB_ASSERT_NOW(lbl, a, c) lbl: assert property (@(posedge clk) disable iff (!arst_n) \
	(a) |-> (c)) else $error("assertion failed");
`define MTGB_ASSERT_NEXT(lbl, a, c) lbl: assert property (@(posedge clk) disable iff (!arst_n) \
	(a) |=> (c)) else $error("assertion failed");
`endif

// ===== src/mtgb_pkg.sv =====
package mtgb_pkg;
	localparam int GENS = 8;
	localparam int GEN_W = 3;
	localparam int IDX_W = 10;
	localparam int ADDR_W = GEN_W + IDX_W;
	localparam logic [IDX_W-1:0] MT_WORDS = 10'd624;
	localparam logic [IDX_W-1:0] MT_LAST = 10'd623;
	localparam logic [IDX_W-1:0] MT_SHIFT = 10'd397;
	localparam logic [31:0] MT_INIT_MULT = 32'd1812433253;
	localparam logic [31:0] MT_MATRIX = 32'h9908b0df;
	localparam logic [31:0] MT_UPPER = 32'h80000000;
	localparam logic [31:0] MT_LOWER = 32'h7fffffff;
	localparam logic [31:0] MT_TEMPER_B = 32'h9d2c5680;
	localparam logic [31:0] MT_TEMPER_C = 32'hefc60000;

	typedef enum logic [3:0] {
		ST_IDLE, ST_SWR, ST_SMUL, ST_SADD, ST_DCHK, ST_TWA, ST_TWB, ST_TWC, ST_DT, ST_FIN
	} state_t;

	typedef struct packed {
		logic load;
		logic seed_wr;
		logic seed_mul;
		logic seed_add;
		logic draw_chk;
		logic tw_a;
		logic tw_b;
		logic tw_c;
		logic draw_t;
		logic finish;
	} cmd_t;

	typedef struct packed {
		logic need_twist;
		logic j_last;
		logic g_last;
		logic k_last;
		logic more_words;
		logic out_free;
	} sts_t;

	function automatic logic [31:0] temper(input logic [31:0] w);
		logic [31:0] y;
		y = w ^ (w >> 11);
		y = y ^ ((y << 7) & MT_TEMPER_B);
		y = y ^ ((y << 15) & MT_TEMPER_C);
		y = y ^ (y >> 18);
		return y;
	endfunction

	function automatic logic [IDX_W-1:0] wrap_next(input logic [IDX_W-1:0] k);
		return (k == MT_LAST) ? '0 : k + 10'd1;
	endfunction

	function automatic logic [IDX_W-1:0] wrap_far(input logic [IDX_W-1:0] k);
		logic [IDX_W:0] s;
		s = {1'b0, k} + {1'b0, MT_SHIFT};
		return (s >= {1'b0, MT_WORDS}) ? IDX_W'(s - {1'b0, MT_WORDS}) : s[IDX_W-1:0];
	endfunction
endpackage

// ===== src/mtgb_ctrl.sv =====
module mtgb_ctrl (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  logic mode,
	input  mtgb_pkg::sts_t sts,
	output logic in_ready,
	output mtgb_pkg::cmd_t cmd
);
	import mtgb_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d = mode ? ST_DCHK : ST_SWR;
				end
			end
			ST_SWR: begin
				cmd.seed_wr = 1'b1;
				if (sts.j_last && sts.g_last) state_d = ST_FIN;
				else if (!sts.j_last) state_d = ST_SMUL;
			end
			ST_SMUL: begin
				cmd.seed_mul = 1'b1;
				state_d = ST_SADD;
			end
			ST_SADD: begin
				cmd.seed_add = 1'b1;
				state_d = ST_SWR;
			end
			ST_DCHK: begin
				cmd.draw_chk = 1'b1;
				state_d = sts.need_twist ? ST_TWA : ST_DT;
			end
			ST_TWA: begin
				cmd.tw_a = 1'b1;
				state_d = ST_TWB;
			end
			ST_TWB: begin
				cmd.tw_b = 1'b1;
				state_d = ST_TWC;
			end
			ST_TWC: begin
				cmd.tw_c = 1'b1;
				state_d = sts.k_last ? ST_DCHK : ST_TWB;
			end
			ST_DT: begin
				cmd.draw_t = 1'b1;
				state_d = sts.more_words ? ST_DCHK : ST_FIN;
			end
			ST_FIN: begin
				if (sts.out_free) begin
					cmd.finish = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end
endmodule

// ===== src/mtgb_datapath.sv =====
module mtgb_datapath (
	input  logic clk,
	input  logic arst_n,
	input  mtgb_pkg::cmd_t cmd,
	input  logic cfg_we,
	input  logic cfg_wdata,
	input  logic mode,
	input  logic [mtgb_pkg::GEN_W-1:0] generator,
	input  logic [31:0] seed,
	input  logic out_ready,
	output mtgb_pkg::sts_t sts,
	output logic out_valid,
	output logic [63:0] random_value
);
	import mtgb_pkg::*;

	logic [31:0] mem [2**ADDR_W];
	logic [31:0] rdata_q, wdata, x_q, prod_q, cur_q, nxt_q, hi_q, seed_q, tword, y;
	logic [ADDR_W-1:0] raddr, waddr;
	logic we;
	logic [IDX_W-1:0] rp_q [GENS];
	logic [IDX_W-1:0] j_q, k_q;
	logic [GEN_W-1:0] gen_q, g_q;
	logic wide_q, first_q, seed_mode_q, out_valid_q;
	logic [63:0] res_q, out_q;

	assign y = (cur_q & MT_UPPER) | (nxt_q & MT_LOWER);
	assign tword = temper(rdata_q);

	always_comb begin
		raddr = '0;
		if (cmd.draw_chk) begin
			raddr = sts.need_twist ? {gen_q, IDX_W'(0)} : {gen_q, rp_q[gen_q]};
		end else if (cmd.tw_a) begin
			raddr = {gen_q, wrap_next(k_q)};
		end else if (cmd.tw_b) begin
			raddr = {gen_q, wrap_far(k_q)};
		end else if (cmd.tw_c) begin
			raddr = {gen_q, wrap_next(wrap_next(k_q))};
		end
		we = cmd.seed_wr | cmd.tw_c;
		waddr = cmd.seed_wr ? {g_q, j_q} : {gen_q, k_q};
		wdata = cmd.seed_wr ? x_q : (rdata_q ^ (y >> 1) ^ (y[0] ? MT_MATRIX : 32'd0));
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	always_comb begin
		sts.need_twist = rp_q[gen_q] >= MT_WORDS;
		sts.j_last = j_q == MT_LAST;
		sts.g_last = g_q == GEN_W'(GENS - 1);
		sts.k_last = k_q == MT_LAST;
		sts.more_words = wide_q && first_q;
		sts.out_free = !out_valid_q || out_ready;
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			gen_q <= generator;
			seed_q <= seed;
			seed_mode_q <= !mode;
			first_q <= 1'b1;
			g_q <= '0;
			j_q <= '0;
			x_q <= seed;
			res_q <= '0;
		end
		if (cmd.seed_wr && sts.j_last) begin
			j_q <= '0;
			g_q <= g_q + GEN_W'(1);
			x_q <= seed_q + 32'(g_q) + 32'd1;
		end
		if (cmd.seed_mul) begin
			prod_q <= MT_INIT_MULT * (x_q ^ (x_q >> 30));
			j_q <= j_q + IDX_W'(1);
		end
		if (cmd.seed_add) begin
			x_q <= prod_q + 32'(j_q);
		end
		if (cmd.draw_chk) begin
			k_q <= '0;
		end
		if (cmd.tw_a) begin
			cur_q <= rdata_q;
		end
		if (cmd.tw_b) begin
			nxt_q <= rdata_q;
		end
		if (cmd.tw_c) begin
			cur_q <= nxt_q;
			k_q <= wrap_next(k_q);
		end
		if (cmd.draw_t) begin
			if (wide_q && first_q) begin
				hi_q <= tword;
				first_q <= 1'b0;
			end else begin
				res_q <= wide_q ? {hi_q, tword} : {32'd0, tword};
			end
		end
		if (cmd.finish) begin
			out_q <= seed_mode_q ? 64'd0 : res_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < GENS; i++) rp_q[i] <= MT_WORDS;
			wide_q <= 1'b1;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) wide_q <= cfg_wdata;
			if (cmd.seed_wr && sts.j_last) rp_q[g_q] <= MT_WORDS;
			if (cmd.tw_c && sts.k_last) rp_q[gen_q] <= '0;
			if (cmd.draw_t) rp_q[gen_q] <= rp_q[gen_q] + IDX_W'(1);
			if (cmd.finish) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign random_value = out_q;
endmodule

// ===== src/mt19937_generator_bank_core.sv =====
// Seed item: each word is written in SWR, with SMUL and SADD between, over 8 x 624 words.
// Draw item: DCHK and DT per word (1 narrow, 2 wide), then FIN loads the output register.
// A draw on an exhausted generator first twists 624 words: TWA, then TWB, TWC per word.
// One item at a time: the next item can be taken once its result is registered.
// Reset is asynchronous: all generators read as exhausted and wide output is on.
module mt19937_generator_bank_core (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic cfg_wdata,
	input  logic in_valid,
	output logic in_ready,
	input  logic mode,
	input  logic [mtgb_pkg::GEN_W-1:0] generator,
	input  logic [31:0] seed,
	output logic out_valid,
	input  logic out_ready,
	output logic [63:0] random_value
);
	import mtgb_pkg::*;

	cmd_t cmd;
	sts_t sts;

	mtgb_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .mode(mode),
		.sts(sts), .in_ready(in_ready), .cmd(cmd)
	);

	mtgb_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.mode(mode), .generator(generator), .seed(seed), .out_ready(out_ready),
		.sts(sts), .out_valid(out_valid), .random_value(random_value)
	);
endmodule

// ===== src/mtgb_checker.sv =====
`include "mt19937_generator_bank_core_assert.svh"
module mtgb_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready
);
	`MTGB_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
	`MTGB_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)
	`MTGB_ASSERT_NOW(a_ready_with_result, $rose(out_valid), in_ready)
endmodule

bind mt19937_generator_bank_core mtgb_checker u_chk (.*);

// ===== verif/tb_mt19937_generator_bank_core.sv =====
module tb_mt19937_generator_bank_core;
	timeunit 1ns;
	timeprecision 1ps;

	import mtgb_pkg::*;

	localparam int WORDS = 624;
	localparam int SHIFT = 397;
	localparam int RANDOM_ITEMS = 1650;
	localparam int SETTLE_CYCLES = 40;
	localparam int HOLD_CYCLES = 400;
	localparam longint CYCLE_LIMIT = 3000000;
	localparam logic MODE_SEED = 1'b0;
	localparam logic MODE_DRAW = 1'b1;

	typedef struct {
		logic mode;
		logic [GEN_W-1:0] gen;
		logic [31:0] seed_val;
		bit known;
		logic [63:0] known_value;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic cfg_wdata = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic mode = MODE_SEED;
	logic [GEN_W-1:0] generator = '0;
	logic [31:0] seed = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [63:0] random_value;

	mt19937_generator_bank_core u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.mode(mode),
		.generator(generator),
		.seed(seed),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.random_value(random_value)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	logic [31:0] bank_words [GENS][WORDS];
	int unsigned bank_pos [GENS];
	bit wide_mode = 1'b1;
	logic [63:0] pending_values [$];
	stim_row_t directed_rows [$];
	bit cur_known = 1'b0;
	logic [63:0] cur_known_value = '0;
	bit item_taken = 1'b0;
	bit calm = 1'b0;
	bit hold_req = 1'b0;
	int hold_left = 0;
	int errors = 0;
	longint cycles = 0;

	function automatic void seed_bank(input logic [31:0] base);
		logic [31:0] x;
		for (int g = 0; g < GENS; g++) begin
			x = base + 32'(g);
			bank_words[g][0] = x;
			for (int j = 1; j < WORDS; j++) begin
				x = MT_INIT_MULT * (x ^ (x >> 30)) + 32'(j);
				bank_words[g][j] = x;
			end
			bank_pos[g] = WORDS;
		end
	endfunction

	function automatic void regenerate(input int g);
		logic [31:0] y;
		logic [31:0] v;
		for (int k = 0; k < WORDS; k++) begin
			y = (bank_words[g][k] & MT_UPPER) | (bank_words[g][(k + 1) % WORDS] & MT_LOWER);
			v = bank_words[g][(k + SHIFT) % WORDS] ^ (y >> 1);
			if (y[0])
				v = v ^ MT_MATRIX;
			bank_words[g][k] = v;
		end
		bank_pos[g] = 0;
	endfunction

	function automatic logic [31:0] next_tempered(input int g);
		logic [31:0] y;
		if (bank_pos[g] >= WORDS)
			regenerate(g);
		y = bank_words[g][bank_pos[g]];
		bank_pos[g]++;
		y = y ^ (y >> 11);
		y = y ^ ((y << 7) & MT_TEMPER_B);
		y = y ^ ((y << 15) & MT_TEMPER_C);
		y = y ^ (y >> 18);
		return y;
	endfunction

	function automatic logic [63:0] predict_value(input logic m, input logic [GEN_W-1:0] g,
			input logic [31:0] s);
		logic [63:0] hi;
		logic [63:0] lo;
		if (m == MODE_SEED) begin
			seed_bank(s);
			return '0;
		end
		if (wide_mode) begin
			hi = {32'd0, next_tempered(int'(g))};
			lo = {32'd0, next_tempered(int'(g))};
			return (hi << 32) ^ lo;
		end
		return {32'd0, next_tempered(int'(g))};
	endfunction

	// Input side: predict every accepted item; output side: check every taken result.
	always @(posedge clk) begin
		logic [63:0] v;
		cycles++;
		item_taken = 1'b0;
		if (arst_n && in_valid && in_ready) begin
			item_taken = 1'b1;
			v = predict_value(mode, generator, seed);
			pending_values.push_back(cur_known ? cur_known_value : v);
		end
		if (arst_n && out_valid && out_ready) begin
			if (pending_values.size() == 0) begin
				$error("random_value: none expected, actual %h", random_value);
				errors++;
			end else begin
				v = pending_values.pop_front();
				if (random_value !== v) begin
					$error("random_value: expected %h, actual %h", v, random_value);
					errors++;
				end
			end
		end
	end

	always @(negedge clk) begin
		if (hold_req) begin
			hold_left = HOLD_CYCLES;
			hold_req = 1'b0;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= calm || ($urandom_range(99) >= 37);
		end
	end

	always @(posedge clk) begin
		if (cycles > CYCLE_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	task automatic send(input logic m, input logic [GEN_W-1:0] g, input logic [31:0] s,
			input bit known, input logic [63:0] known_value);
		int gap;
		in_valid <= 1'b1;
		mode <= m;
		generator <= g;
		seed <= s;
		cur_known = known;
		cur_known_value = known_value;
		do
			@(negedge clk);
		while (!item_taken);
		cur_known = 1'b0;
		if (!calm && $urandom_range(99) < 37) begin
			gap = $urandom_range(1, 6);
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(negedge clk);
		while (pending_values.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic set_wide(input bit w);
		cfg_we <= 1'b1;
		cfg_wdata <= w;
		@(negedge clk);
		cfg_we <= 1'b0;
		wide_mode = w;
		@(negedge clk);
	endtask

	task automatic add_row(input logic m, input logic [GEN_W-1:0] g, input logic [31:0] s,
			input bit known, input logic [63:0] known_value);
		stim_row_t r;
		r.mode = m;
		r.gen = g;
		r.seed_val = s;
		r.known = known;
		r.known_value = known_value;
		directed_rows.push_back(r);
	endtask

	initial begin
		int narrow_from;
		logic [GEN_W-1:0] g;
		add_row(MODE_SEED, 3'd0, 32'd5489, 1'b1, 64'd0);
		add_row(MODE_DRAW, 3'd0, 32'd0, 1'b1, 64'hd091bb5c_22ae9ef6);
		add_row(MODE_DRAW, 3'd7, 32'hffffffff, 1'b0, 64'd0);
		add_row(MODE_DRAW, 3'd0, 32'd0, 1'b0, 64'd0);
		add_row(MODE_SEED, 3'd7, 32'd0, 1'b1, 64'd0);
		for (int i = 0; i < GENS; i++)
			add_row(MODE_DRAW, GEN_W'(i), 32'(i), 1'b0, 64'd0);
		add_row(MODE_SEED, 3'd0, 32'hffffffff, 1'b1, 64'd0);
		add_row(MODE_DRAW, 3'd1, 32'd0, 1'b0, 64'd0);
		add_row(MODE_DRAW, 3'd7, 32'd0, 1'b0, 64'd0);
		add_row(MODE_SEED, 3'd5, 32'd5489, 1'b1, 64'd0);
		narrow_from = directed_rows.size();
		add_row(MODE_DRAW, 3'd0, 32'd0, 1'b1, 64'h00000000_d091bb5c);
		add_row(MODE_DRAW, 3'd0, 32'd0, 1'b1, 64'h00000000_22ae9ef6);
		add_row(MODE_DRAW, 3'd5, 32'd0, 1'b0, 64'd0);
		add_row(MODE_SEED, 3'd0, 32'h55555555, 1'b1, 64'd0);
		add_row(MODE_DRAW, 3'd2, 32'd0, 1'b0, 64'd0);
		add_row(MODE_SEED, 3'd0, 32'haaaaaaaa, 1'b1, 64'd0);
		add_row(MODE_DRAW, 3'd6, 32'd0, 1'b0, 64'd0);

		repeat (3) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (directed_rows[i]) begin
			if (i == narrow_from) begin
				drain();
				set_wide(1'b0);
			end
			send(directed_rows[i].mode, directed_rows[i].gen, directed_rows[i].seed_val,
				directed_rows[i].known, directed_rows[i].known_value);
		end
		drain();
		set_wide(1'b1);

		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i > 0 && i % 400 == 0) begin
				drain();
				set_wide(!wide_mode);
			end
			if (i == 300)
				hold_req = 1'b1;
			if (i == 700)
				drain();
			calm = (i >= 900 && i < 1100);
			g = GEN_W'($urandom_range(GENS - 1));
			if ($urandom_range(149) == 0)
				send(MODE_SEED, g, $urandom, 1'b0, 64'd0);
			else
				send(MODE_DRAW, g, $urandom, 1'b0, 64'd0);
		end
		calm = 1'b0;
		drain();

		if (errors == 0 && pending_values.size() == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end
endmodule
